// ===== rtl/bps_pkg.sv =====
// ----------------------------------------------------------------------------
// bps_pkg
// Types, latencies and helpers shared by the two-light Blinn-Phong shader core.
// ----------------------------------------------------------------------------
package bps_pkg;

   typedef logic [31:0]        mag_type;     // unsigned magnitude, pre-scaled
   typedef logic signed [31:0] q30_type;     // signed Q2.30 unit component
   typedef mag_type [2:0]      mag_vec_type;
   typedef q30_type [2:0]      q30_vec_type;
   typedef logic [30:0]        cos_type;     // Q2.30 value in 0..1.0
   typedef logic [32:0]        att_type;     // Q2.30 value in 0..4.0

   typedef enum logic [2:0] {
      CSR_LIGHT_A   = 3'd0,
      CSR_LIGHT_B   = 3'd1,
      CSR_EYE       = 3'd2,
      CSR_INTENSITY = 3'd3,
      CSR_AMBIENT   = 3'd4,
      CSR_SPECULAR  = 3'd5
   } csr_index_type;

   localparam logic [47:0] LIGHT_A_RESET   = 48'd21990568104960;
   localparam logic [47:0] LIGHT_B_RESET   = 48'd335604736;
   localparam logic [47:0] EYE_RESET       = 48'd10995116277760;
   localparam logic [15:0] INTENSITY_RESET = 16'd500;
   localparam logic [15:0] AMBIENT_RESET   = 16'd3277;
   localparam logic [15:0] SPECULAR_RESET  = 16'd52017;

   // unit latencies, in clock cycles from operands to result
   localparam int LAT_SQRT = 32;
   localparam int NORM_QB  = 31;
   localparam int NORM_CAP = 30;
   localparam int LAT_NORM = 2 + LAT_SQRT + NORM_QB + 1 + 1;
   localparam int LAT_DOT  = 3;
   localparam int LAT_POW  = 8;
   localparam int ATT_DW   = 34;
   localparam int ATT_QB   = 33;
   localparam int ATT_CAP  = 32;
   localparam int LAT_ATT  = 2 + ATT_QB + 1;

   // alignment delays in the top level
   localparam int D_NRM   = 1 + LAT_NORM;
   localparam int D_COSL  = 1 + LAT_NORM + LAT_POW;
   localparam int D_ATT   = 2 * LAT_NORM + 1 + LAT_DOT + LAT_POW - LAT_ATT;
   localparam int D_COL   = 2 * LAT_NORM + LAT_DOT + LAT_POW + 3;
   localparam int D_VALID = D_COL + 3;

   function automatic logic [16:0] sdiff(input logic [15:0] a, input logic [15:0] b);
      return {a[15], a} - {b[15], b};
   endfunction

   // |v| scaled by 2^14, as the normalizer expects for Q8.8 and Q1.14 inputs
   function automatic mag_type scaled_mag(input logic [16:0] v);
      logic [16:0] a;
      a = v[16] ? (~v + 17'd1) : v;
      return {2'b00, a[15:0], 14'd0};
   endfunction

endpackage

// ===== rtl/bps_delay.sv =====
// ----------------------------------------------------------------------------
// bps_delay
// Fixed-length register delay line for aligning operands across the pipeline.
// ----------------------------------------------------------------------------
module bps_delay #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic [WIDTH-1:0] data_in,
   output logic [WIDTH-1:0] data_out
);

   logic [WIDTH-1:0] tap_ff [DEPTH];

   always_ff @(posedge clock) begin
      tap_ff[0] <= data_in;
      for (int i = 1; i < DEPTH; i++) begin
         tap_ff[i] <= tap_ff[i-1];
      end
   end

   assign data_out = tap_ff[DEPTH-1];

endmodule

// ===== rtl/bps_isqrt.sv =====
// ----------------------------------------------------------------------------
// bps_isqrt
// Pipelined integer square root, 64-bit radicand, one result bit per stage.
// ----------------------------------------------------------------------------
module bps_isqrt (
   input  logic        clock,
   input  logic [63:0] rad_in,
   output logic [31:0] root_out
);

   logic [63:0] x_ff [bps_pkg::LAT_SQRT];
   logic [63:0] r_ff [bps_pkg::LAT_SQRT];

   for (genvar i = 0; i < bps_pkg::LAT_SQRT; i++) begin : g_step
      localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
      logic [63:0] x_cur, r_cur, trial, x_in, r_in;
      if (i == 0) begin : g_first
         assign x_cur = rad_in;
         assign r_cur = '0;
      end else begin : g_next
         assign x_cur = x_ff[i-1];
         assign r_cur = r_ff[i-1];
      end
      assign trial = r_cur + BIT;
      always_comb begin
         if (x_cur >= trial) begin
            x_in = x_cur - trial;
            r_in = (r_cur >> 1) + BIT;
         end else begin
            x_in = x_cur;
            r_in = r_cur >> 1;
         end
      end
      always_ff @(posedge clock) begin
         x_ff[i] <= x_in;
         r_ff[i] <= r_in;
      end
   end

   assign root_out = r_ff[bps_pkg::LAT_SQRT-1][31:0];

endmodule

// ===== rtl/bps_div.sv =====
// ----------------------------------------------------------------------------
// bps_div
// Pipelined restoring divider, 64-bit dividend, quotient clamped to 2^CAP.
// ----------------------------------------------------------------------------
module bps_div #(
   parameter int DW       = 32,
   parameter int QB       = 31,
   parameter int CAP      = 30,
   parameter bit ZERO_OUT = 1'b1
) (
   input  logic          clock,
   input  logic [63:0]   num_in,
   input  logic [DW-1:0] den_in,
   output logic [CAP:0]  quo_out
);

   localparam int W = (DW + QB > 64) ? DW + QB : 64;
   localparam logic [QB-1:0] CAP_VAL = QB'(1) << CAP;

   logic [W-1:0]  rem_ff  [QB+1];
   logic [DW-1:0] den_ff  [QB+1];
   logic [QB-1:0] quo_ff  [QB+1];
   logic          sat_ff  [QB+1];
   logic          zero_ff [QB+1];

   // first stage: quotient too large for QB bits saturates
   always_ff @(posedge clock) begin
      rem_ff[0]  <= W'(num_in);
      den_ff[0]  <= den_in;
      quo_ff[0]  <= '0;
      sat_ff[0]  <= W'(num_in) >= (W'(den_in) << QB);
      zero_ff[0] <= den_in == '0;
   end

   for (genvar j = 1; j <= QB; j++) begin : g_step
      localparam int K = QB - j;
      logic [W-1:0]  shifted, rem_in;
      logic [QB-1:0] quo_in;
      assign shifted = W'(den_ff[j-1]) << K;
      always_comb begin
         rem_in = rem_ff[j-1];
         quo_in = quo_ff[j-1];
         if (rem_ff[j-1] >= shifted) begin
            rem_in    = rem_ff[j-1] - shifted;
            quo_in[K] = 1'b1;
         end
      end
      always_ff @(posedge clock) begin
         rem_ff[j]  <= rem_in;
         den_ff[j]  <= den_ff[j-1];
         quo_ff[j]  <= quo_in;
         sat_ff[j]  <= sat_ff[j-1];
         zero_ff[j] <= zero_ff[j-1];
      end
   end

   always_comb begin
      if (ZERO_OUT && zero_ff[QB]) begin
         quo_out = '0;
      end else if (sat_ff[QB] || quo_ff[QB] > CAP_VAL) begin
         quo_out = CAP_VAL[CAP:0];
      end else begin
         quo_out = quo_ff[QB][CAP:0];
      end
   end

endmodule

// ===== rtl/bps_norm.sv =====
// ----------------------------------------------------------------------------
// bps_norm
// Vector normalizer: sum of squares, square root, three divides, Q2.30 out.
// ----------------------------------------------------------------------------
module bps_norm (
   input  logic                      clock,
   input  bps_pkg::mag_vec_type      mag_in,
   input  logic [2:0]                neg_in,
   output bps_pkg::q30_vec_type      unit_out
);

   localparam int D_MAG = 2 + bps_pkg::LAT_SQRT;
   localparam int D_NEG = D_MAG + bps_pkg::NORM_QB + 1;

   logic [2:0][63:0]     sq_ff;
   logic [63:0]          sum_ff;
   logic [31:0]          root;
   bps_pkg::mag_vec_type mag_d;
   logic [2:0]           neg_d;
   bps_pkg::q30_vec_type unit_ff;

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         sq_ff[i] <= 64'(mag_in[i]) * 64'(mag_in[i]);
      end
      sum_ff <= sq_ff[0] + sq_ff[1] + sq_ff[2];
   end

   bps_isqrt u_isqrt (
      .clock    (clock),
      .rad_in   (sum_ff),
      .root_out (root)
   );

   bps_delay #(.WIDTH(96), .DEPTH(D_MAG)) u_mag_dly (
      .clock    (clock),
      .data_in  (mag_in),
      .data_out (mag_d)
   );

   bps_delay #(.WIDTH(3), .DEPTH(D_NEG)) u_neg_dly (
      .clock    (clock),
      .data_in  (neg_in),
      .data_out (neg_d)
   );

   for (genvar i = 0; i < 3; i++) begin : g_axis
      bps_pkg::cos_type quo;
      bps_div #(
         .DW       (32),
         .QB       (bps_pkg::NORM_QB),
         .CAP      (bps_pkg::NORM_CAP),
         .ZERO_OUT (1'b1)
      ) u_div (
         .clock   (clock),
         .num_in  ({2'b00, mag_d[i], 30'd0}),
         .den_in  (root),
         .quo_out (quo)
      );
      always_ff @(posedge clock) begin
         unit_ff[i] <= neg_d[i] ? -{1'b0, quo} : {1'b0, quo};
      end
   end

   assign unit_out = unit_ff;

endmodule

// ===== rtl/bps_dot.sv =====
// ----------------------------------------------------------------------------
// bps_dot
// Clamped cosine of two Q2.30 unit vectors: products, sum, clamp to 0..1.0.
// ----------------------------------------------------------------------------
module bps_dot (
   input  logic                 clock,
   input  bps_pkg::q30_vec_type a_in,
   input  bps_pkg::q30_vec_type b_in,
   output bps_pkg::cos_type     cos_out
);

   localparam logic signed [65:0] ONE = 66'sd1073741824;

   logic signed [2:0][63:0] prod_ff;
   logic signed [65:0]      sum_ff;
   logic signed [65:0]      shifted;
   bps_pkg::cos_type        cos_ff, cos_in;

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         prod_ff[i] <= $signed(a_in[i]) * $signed(b_in[i]);
      end
      sum_ff <= $signed({{2{prod_ff[0][63]}}, prod_ff[0]})
              + $signed({{2{prod_ff[1][63]}}, prod_ff[1]})
              + $signed({{2{prod_ff[2][63]}}, prod_ff[2]});
      cos_ff <= cos_in;
   end

   assign shifted = sum_ff >>> 30;

   always_comb begin
      if (sum_ff <= 66'sd0) begin
         cos_in = '0;
      end else if (shifted > ONE) begin
         cos_in = ONE[30:0];
      end else begin
         cos_in = shifted[30:0];
      end
   end

   assign cos_out = cos_ff;

endmodule

// ===== rtl/bps_pow.sv =====
// ----------------------------------------------------------------------------
// bps_pow
// Shininess power by square-and-multiply, one exponent bit per stage.
// ----------------------------------------------------------------------------
module bps_pow #(
   parameter int SHIN = 150
) (
   input  logic             clock,
   input  bps_pkg::cos_type base_in,
   output bps_pkg::cos_type pow_out
);

   localparam logic [7:0]  EXP = 8'(SHIN);
   localparam logic [30:0] ONE = 31'd1 << 30;

   bps_pkg::cos_type r_ff [bps_pkg::LAT_POW];
   bps_pkg::cos_type c_ff [bps_pkg::LAT_POW];

   for (genvar i = 0; i < bps_pkg::LAT_POW; i++) begin : g_bit
      bps_pkg::cos_type r_cur, c_cur;
      logic [61:0]      rc, cc;
      if (i == 0) begin : g_first
         assign r_cur = ONE;
         assign c_cur = base_in;
      end else begin : g_next
         assign r_cur = r_ff[i-1];
         assign c_cur = c_ff[i-1];
      end
      assign rc = 62'(r_cur) * 62'(c_cur);
      assign cc = 62'(c_cur) * 62'(c_cur);
      always_ff @(posedge clock) begin
         r_ff[i] <= EXP[i] ? rc[60:30] : r_cur;
         c_ff[i] <= cc[60:30];
      end
   end

   assign pow_out = r_ff[bps_pkg::LAT_POW-1];

endmodule

// ===== rtl/blinn_phong_two_light_shader_core.sv =====
// ----------------------------------------------------------------------------
// blinn_phong_two_light_shader_core
// Two point-light Blinn-Phong fragment shader, fixed point, fully pipelined.
// ----------------------------------------------------------------------------
// One fragment transaction is taken in every clock cycle (start high, busy
// low; busy is high only while reset is asserted). The shaded color appears
// on the rsp_ ports with rsp_valid high for one cycle; the receiver cannot
// stall, and results leave in the order fragments came in. The latency is
// set by two normalizers in series (square root then three divides, one bit
// per stage each), the cosine products and the eight-stage shininess power.
// The csr_ registers are read directly by the pipeline, so write them only
// with no fragment in flight.
module blinn_phong_two_light_shader_core #(
   parameter int SHININESS = 150
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [7:0]         req_color_red,
   input  logic [7:0]         req_color_green,
   input  logic [7:0]         req_color_blue,
   input  logic signed [15:0] req_normal_x,
   input  logic signed [15:0] req_normal_y,
   input  logic signed [15:0] req_normal_z,
   input  logic signed [15:0] req_point_x,
   input  logic signed [15:0] req_point_y,
   input  logic signed [15:0] req_point_z,
   output logic               rsp_valid,
   output logic [7:0]         rsp_out_red,
   output logic [7:0]         rsp_out_green,
   output logic [7:0]         rsp_out_blue,
   input  logic               csr_write_en,
   input  logic [2:0]         csr_index,
   input  logic [47:0]        csr_wdata
);

   // configuration registers
   logic [47:0] light_a_ff, light_b_ff, eye_ff;
   logic [15:0] intensity_ff, ambient_ff, specular_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         light_a_ff   <= bps_pkg::LIGHT_A_RESET;
         light_b_ff   <= bps_pkg::LIGHT_B_RESET;
         eye_ff       <= bps_pkg::EYE_RESET;
         intensity_ff <= bps_pkg::INTENSITY_RESET;
         ambient_ff   <= bps_pkg::AMBIENT_RESET;
         specular_ff  <= bps_pkg::SPECULAR_RESET;
      end else if (csr_write_en) begin
         unique case (bps_pkg::csr_index_type'(csr_index))
            bps_pkg::CSR_LIGHT_A:   light_a_ff   <= csr_wdata;
            bps_pkg::CSR_LIGHT_B:   light_b_ff   <= csr_wdata;
            bps_pkg::CSR_EYE:       eye_ff       <= csr_wdata;
            bps_pkg::CSR_INTENSITY: intensity_ff <= csr_wdata[15:0];
            bps_pkg::CSR_AMBIENT:   ambient_ff   <= csr_wdata[15:0];
            bps_pkg::CSR_SPECULAR:  specular_ff  <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   assign busy = reset;

   // stage 0: capture transaction
   logic             valid_s0_ff, valid_s1_ff;
   logic [2:0][7:0]  col_s0_ff, col_s1_ff;
   logic [2:0][15:0] nrm_s0_ff, pnt_s0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_s0_ff <= 1'b0;
         valid_s1_ff <= 1'b0;
      end else begin
         valid_s0_ff <= start && !busy;
         valid_s1_ff <= valid_s0_ff;
      end
   end

   always_ff @(posedge clock) begin
      col_s0_ff <= {req_color_blue, req_color_green, req_color_red};
      nrm_s0_ff <= {req_normal_z, req_normal_y, req_normal_x};
      pnt_s0_ff <= {req_point_z, req_point_y, req_point_x};
   end

   // stage 1: difference vectors, pre-scaled magnitudes and signs
   logic [1:0][47:0]      lgt_pos;
   logic [2:0][16:0]      nrm_d, eye_d;
   logic [1:0][2:0][16:0] lgt_d;

   bps_pkg::mag_vec_type        nrm_w_ff, eye_w_ff;
   bps_pkg::mag_vec_type [1:0]  lgt_w_ff;
   logic [2:0]                  nrm_neg_ff, eye_neg_ff;
   logic [1:0][2:0]             lgt_neg_ff;

   assign lgt_pos = {light_b_ff, light_a_ff};

   for (genvar i = 0; i < 3; i++) begin : g_s1
      assign nrm_d[i]    = bps_pkg::sdiff(nrm_s0_ff[i], 16'd0);
      assign eye_d[i]    = bps_pkg::sdiff(eye_ff[16*i +: 16], pnt_s0_ff[i]);
      assign lgt_d[0][i] = bps_pkg::sdiff(lgt_pos[0][16*i +: 16], pnt_s0_ff[i]);
      assign lgt_d[1][i] = bps_pkg::sdiff(lgt_pos[1][16*i +: 16], pnt_s0_ff[i]);
      always_ff @(posedge clock) begin
         nrm_w_ff[i]      <= bps_pkg::scaled_mag(nrm_d[i]);
         nrm_neg_ff[i]    <= nrm_d[i][16];
         eye_w_ff[i]      <= bps_pkg::scaled_mag(eye_d[i]);
         eye_neg_ff[i]    <= eye_d[i][16];
         lgt_w_ff[0][i]   <= bps_pkg::scaled_mag(lgt_d[0][i]);
         lgt_neg_ff[0][i] <= lgt_d[0][i][16];
         lgt_w_ff[1][i]   <= bps_pkg::scaled_mag(lgt_d[1][i]);
         lgt_neg_ff[1][i] <= lgt_d[1][i][16];
      end
   end

   always_ff @(posedge clock) begin
      col_s1_ff <= col_s0_ff;
   end

   // normal and view direction
   bps_pkg::q30_vec_type nrm_u, eye_u, nrm_u_d;

   bps_norm u_norm_n (
      .clock    (clock),
      .mag_in   (nrm_w_ff),
      .neg_in   (nrm_neg_ff),
      .unit_out (nrm_u)
   );

   bps_norm u_norm_v (
      .clock    (clock),
      .mag_in   (eye_w_ff),
      .neg_in   (eye_neg_ff),
      .unit_out (eye_u)
   );

   bps_delay #(.WIDTH(96), .DEPTH(bps_pkg::D_NRM)) u_nrm_dly (
      .clock    (clock),
      .data_in  (nrm_u),
      .data_out (nrm_u_d)
   );

   // per-light datapath
   bps_pkg::att_type [1:0] att, att_d;
   bps_pkg::cos_type [1:0] cos_l_d, pow_h;
   logic [1:0][32:0]       spec1_ff, diff_ff, spec_ff, diff2_ff;

   for (genvar j = 0; j < 2; j++) begin : g_light
      logic [2:0][31:0]     r2sq_ff;
      logic [33:0]          r2_ff;
      bps_pkg::q30_vec_type lgt_u, half_u;
      bps_pkg::mag_vec_type hs_w_ff;
      logic [2:0]           hs_neg_ff;
      bps_pkg::cos_type     cos_l, cos_h;
      logic [63:0]          spec_prod, diff_prod;
      logic [48:0]          gain_prod;

      // attenuation: intensity / r^2 in Q2.30, saturating at 4.0
      always_ff @(posedge clock) begin
         for (int i = 0; i < 3; i++) begin
            r2sq_ff[i] <= 32'(lgt_w_ff[j][i][29:14]) * 32'(lgt_w_ff[j][i][29:14]);
         end
         r2_ff <= 34'(r2sq_ff[0]) + 34'(r2sq_ff[1]) + 34'(r2sq_ff[2]);
      end

      bps_div #(
         .DW       (bps_pkg::ATT_DW),
         .QB       (bps_pkg::ATT_QB),
         .CAP      (bps_pkg::ATT_CAP),
         .ZERO_OUT (1'b0)
      ) u_att_div (
         .clock   (clock),
         .num_in  ({2'b00, intensity_ff, 46'd0}),
         .den_in  (r2_ff),
         .quo_out (att[j])
      );

      bps_delay #(.WIDTH(33), .DEPTH(bps_pkg::D_ATT)) u_att_dly (
         .clock    (clock),
         .data_in  (att[j]),
         .data_out (att_d[j])
      );

      bps_norm u_norm_l (
         .clock    (clock),
         .mag_in   (lgt_w_ff[j]),
         .neg_in   (lgt_neg_ff[j]),
         .unit_out (lgt_u)
      );

      bps_dot u_dot_l (
         .clock   (clock),
         .a_in    (nrm_u),
         .b_in    (lgt_u),
         .cos_out (cos_l)
      );

      bps_delay #(.WIDTH(31), .DEPTH(bps_pkg::D_COSL)) u_cos_dly (
         .clock    (clock),
         .data_in  (cos_l),
         .data_out (cos_l_d[j])
      );

      // half vector l + v
      for (genvar i = 0; i < 3; i++) begin : g_half
         logic signed [32:0] hs;
         logic [32:0]        hs_abs;
         assign hs     = $signed({lgt_u[i][31], lgt_u[i]}) + $signed({eye_u[i][31], eye_u[i]});
         assign hs_abs = hs[32] ? -hs : hs;
         always_ff @(posedge clock) begin
            hs_w_ff[i]   <= hs_abs[31:0];
            hs_neg_ff[i] <= hs[32];
         end
      end

      bps_norm u_norm_h (
         .clock    (clock),
         .mag_in   (hs_w_ff),
         .neg_in   (hs_neg_ff),
         .unit_out (half_u)
      );

      bps_dot u_dot_h (
         .clock   (clock),
         .a_in    (nrm_u_d),
         .b_in    (half_u),
         .cos_out (cos_h)
      );

      bps_pow #(.SHIN(SHININESS)) u_pow (
         .clock   (clock),
         .base_in (cos_h),
         .pow_out (pow_h[j])
      );

      assign spec_prod = 64'(att_d[j]) * 64'(pow_h[j]);
      assign diff_prod = 64'(att_d[j]) * 64'(cos_l_d[j]);
      assign gain_prod = 49'(spec1_ff[j]) * 49'(specular_ff);

      always_ff @(posedge clock) begin
         spec1_ff[j] <= spec_prod[62:30];
         diff_ff[j]  <= diff_prod[62:30];
         spec_ff[j]  <= gain_prod[48:16];
         diff2_ff[j] <= diff_ff[j];
      end
   end

   // channel sums
   logic [2:0][7:0]  col_d, col_f1_ff;
   logic [33:0]      dsum_ff, ssum_ff;
   logic [2:0][23:0] amb_ff, amb_f2_ff;
   logic [2:0][41:0] dterm_ff;
   logic [41:0]      sterm_ff;
   logic [2:0][7:0]  out_ff;

   bps_delay #(.WIDTH(24), .DEPTH(bps_pkg::D_COL)) u_col_dly (
      .clock    (clock),
      .data_in  (col_s1_ff),
      .data_out (col_d)
   );

   always_ff @(posedge clock) begin
      dsum_ff   <= 34'(diff2_ff[0]) + 34'(diff2_ff[1]);
      ssum_ff   <= 34'(spec_ff[0]) + 34'(spec_ff[1]);
      col_f1_ff <= col_d;
      sterm_ff  <= 42'(ssum_ff) * 42'd255;
      for (int i = 0; i < 3; i++) begin
         amb_ff[i]    <= 24'(ambient_ff) * 24'(col_d[i]);
         dterm_ff[i]  <= 42'(col_f1_ff[i]) * 42'(dsum_ff);
         amb_f2_ff[i] <= amb_ff[i];
      end
   end

   for (genvar i = 0; i < 3; i++) begin : g_out
      logic [43:0] acc;
      // ambient counts once per light, hence the extra shift
      assign acc = 44'({amb_f2_ff[i], 15'd0}) + 44'(dterm_ff[i]) + 44'(sterm_ff)
                 + (44'd1 << 29);
      always_ff @(posedge clock) begin
         out_ff[i] <= (|acc[43:38]) ? 8'hFF : acc[37:30];
      end
   end

   // transaction valid travels alongside the datapath
   logic [bps_pkg::D_VALID-1:0] valid_pipe_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_pipe_ff <= '0;
      end else begin
         valid_pipe_ff <= {valid_pipe_ff[bps_pkg::D_VALID-2:0], valid_s1_ff};
      end
   end

   assign rsp_valid     = valid_pipe_ff[bps_pkg::D_VALID-1];
   assign rsp_out_red   = out_ff[0];
   assign rsp_out_green = out_ff[1];
   assign rsp_out_blue  = out_ff[2];

`ifndef NO_ASSERTIONS
   a_latency : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##153 rsp_valid)
      else $error("accepted transaction did not produce a result on time");

   a_att_cap : assert property (@(posedge clock) disable iff (reset)
      valid_pipe_ff[bps_pkg::LAT_ATT-1] |->
         (att[0] <= (33'd1 << 32) && att[1] <= (33'd1 << 32)))
      else $error("attenuation above 4.0");
`endif

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-light Blinn-Phong shader core testbench
// Drives fragments and register writes into the shader core, predicts each
// shaded color with a bit-exact fixed-point model and compares results in
// order. It covers directed corner fragments, random fragments under several
// register settings and varying input gaps.
// ----------------------------------------------------------------------------
module testbench;

   typedef longint vec3_type [3];

   typedef struct packed {
      logic [7:0]         red;
      logic [7:0]         green;
      logic [7:0]         blue;
      logic signed [15:0] nx;
      logic signed [15:0] ny;
      logic signed [15:0] nz;
      logic signed [15:0] px;
      logic signed [15:0] py;
      logic signed [15:0] pz;
   } fragment_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } shade_type;

   localparam logic [2:0] CSR_SPARE_LO = 3'd6;   // unmapped indexes
   localparam logic [2:0] CSR_SPARE_HI = 3'd7;
   localparam longint     ONE_Q30      = 64'sd1 << 30;
   localparam int         SHININESS_TB = 150;

   class shade_scoreboard;
      logic [47:0] light_a, light_b, eye;
      logic [15:0] intensity, ambient, specular;
      shade_type   expected_q[$];
      int          errors;

      function void set_defaults();
         light_a   = bps_pkg::LIGHT_A_RESET;
         light_b   = bps_pkg::LIGHT_B_RESET;
         eye       = bps_pkg::EYE_RESET;
         intensity = bps_pkg::INTENSITY_RESET;
         ambient   = bps_pkg::AMBIENT_RESET;
         specular  = bps_pkg::SPECULAR_RESET;
         errors    = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [47:0] data);
         case (idx)
            bps_pkg::CSR_LIGHT_A:   light_a   = data;
            bps_pkg::CSR_LIGHT_B:   light_b   = data;
            bps_pkg::CSR_EYE:       eye       = data;
            bps_pkg::CSR_INTENSITY: intensity = data[15:0];
            bps_pkg::CSR_AMBIENT:   ambient   = data[15:0];
            bps_pkg::CSR_SPECULAR:  specular  = data[15:0];
            default: ;
         endcase
      endfunction

      function longint unsigned magnitude(longint a);
         return a < 0 ? longint'(0) - a : a;
      endfunction

      function longint unsigned int_sqrt(longint unsigned x);
         longint unsigned r, b;
         r = 0;
         b = 64'h4000_0000_0000_0000;
         while (b > x) b = b >> 2;
         while (b != 0) begin
            if (x >= r + b) begin
               x = x - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         return r;
      endfunction

      function void to_unit(vec3_type v, int pre, output vec3_type u);
         longint unsigned s, m, q;
         s = 0;
         for (int i = 0; i < 3; i++) s += magnitude(v[i]) * magnitude(v[i]);
         m = int_sqrt(s << (2 * pre));
         for (int i = 0; i < 3; i++) begin
            if (m == 0) begin
               u[i] = 0;
            end else begin
               q = (magnitude(v[i]) << (30 + pre)) / m;
               if (q > ONE_Q30) q = ONE_Q30;
               u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
            end
         end
      endfunction

      function longint unsigned cosine(vec3_type a, vec3_type b);
         longint s;
         s = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
         if (s <= 0) return 0;
         s = s >>> 30;
         return s > ONE_Q30 ? ONE_Q30 : s;
      endfunction

      function longint unsigned shine_power(longint unsigned c);
         longint unsigned r;
         logic [7:0] e;
         r = ONE_Q30;
         e = 8'(SHININESS_TB);
         for (int i = 0; i < 8; i++) begin
            if (e[i]) r = (r * c) >> 30;
            c = (c * c) >> 30;
         end
         return r;
      endfunction

      function void light_term(logic [47:0] pos, vec3_type p, vec3_type n, vec3_type v,
                               longint unsigned col [3], ref longint unsigned acc [3]);
         vec3_type d, l, hs, h;
         longint unsigned r2, att, diff, spec;
         r2 = 0;
         for (int i = 0; i < 3; i++) begin
            d[i] = longint'($signed(pos[16*i +: 16])) - p[i];
            r2 += magnitude(d[i]) * magnitude(d[i]);
         end
         to_unit(d, 14, l);
         for (int i = 0; i < 3; i++) hs[i] = l[i] + v[i];
         to_unit(hs, 0, h);
         if (r2 == 0) begin
            att = 64'd1 << 32;
         end else begin
            att = (longint'(intensity) << 46) / r2;
            if (att > (64'd1 << 32)) att = 64'd1 << 32;
         end
         diff = (att * cosine(n, l)) >> 30;
         spec = (((att * shine_power(cosine(n, h))) >> 30) * specular) >> 16;
         for (int i = 0; i < 3; i++)
            acc[i] += ((longint'(ambient) * col[i]) << 14) + col[i] * diff + 255 * spec;
      endfunction

      function void note_fragment(fragment_type f);
         longint unsigned col [3], acc [3], o [3];
         vec3_type nraw, n, p, e, v;
         shade_type item;
         col  = '{f.red, f.green, f.blue};
         nraw = '{longint'($signed(f.nx)), longint'($signed(f.ny)), longint'($signed(f.nz))};
         p    = '{longint'($signed(f.px)), longint'($signed(f.py)), longint'($signed(f.pz))};
         acc  = '{0, 0, 0};
         for (int i = 0; i < 3; i++) e[i] = longint'($signed(eye[16*i +: 16])) - p[i];
         to_unit(nraw, 14, n);
         to_unit(e, 14, v);
         light_term(light_a, p, n, v, col, acc);
         light_term(light_b, p, n, v, col, acc);
         for (int i = 0; i < 3; i++) begin
            o[i] = (acc[i] + (64'd1 << 29)) >> 30;
            if (o[i] > 255) o[i] = 255;
         end
         item = '{8'(o[0]), 8'(o[1]), 8'(o[2])};
         expected_q = {expected_q, item};
      endfunction

      function void check_shade(shade_type got);
         shade_type want;
         if (expected_q.size() == 0) begin
            $error("unexpected result transaction: %p", got);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         if (got.red !== want.red) begin
            $error("out_red: expected %0d, actual %0d", want.red, got.red);
            errors++;
         end
         if (got.green !== want.green) begin
            $error("out_green: expected %0d, actual %0d", want.green, got.green);
            errors++;
         end
         if (got.blue !== want.blue) begin
            $error("out_blue: expected %0d, actual %0d", want.blue, got.blue);
            errors++;
         end
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   fragment_type frag = '0;
   logic         rsp_valid;
   logic [7:0]   rsp_out_red, rsp_out_green, rsp_out_blue;
   logic         csr_write_en = 1'b0;
   logic [2:0]   csr_index = '0;
   logic [47:0]  csr_wdata = '0;

   shade_scoreboard sb = new();
   int              idle_pct;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   blinn_phong_two_light_shader_core #(.SHININESS(SHININESS_TB)) i_dut (
      .clock, .reset, .start, .busy,
      .req_color_red(frag.red), .req_color_green(frag.green), .req_color_blue(frag.blue),
      .req_normal_x(frag.nx), .req_normal_y(frag.ny), .req_normal_z(frag.nz),
      .req_point_x(frag.px), .req_point_y(frag.py), .req_point_z(frag.pz),
      .rsp_valid, .rsp_out_red, .rsp_out_green, .rsp_out_blue,
      .csr_write_en, .csr_index, .csr_wdata
   );

   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) sb.note_fragment(frag);
         if (rsp_valid) sb.check_shade({rsp_out_red, rsp_out_green, rsp_out_blue});
      end
   end

   // idle cycles are drawn one at a time, so idle_pct is the idle share
   task automatic send_fragment(fragment_type f);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         frag  <= fragment_type'({$urandom, $urandom, $urandom, $urandom});
         @(negedge clock);
      end
      start <= 1'b1;
      frag  <= f;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] idx, logic [47:0] data);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      sb.write_reg(idx, data);
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   // hold off the sender until the pipeline is empty
   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   function automatic logic [15:0] near_coord();
      return 16'($signed($urandom_range(12800)) - 6400);   // +-25.0 in Q8.8
   endfunction

   function automatic fragment_type random_fragment();
      fragment_type f;
      f = fragment_type'({$urandom, $urandom, $urandom, $urandom});
      if ($urandom_range(9) < 8) begin
         f.nx = 16'($signed($urandom_range(32768)) - 16384);
         f.ny = 16'($signed($urandom_range(32768)) - 16384);
         f.nz = 16'($signed($urandom_range(32768)) - 16384);
         f.px = near_coord();
         f.py = near_coord();
         f.pz = near_coord();
      end
      return f;
   endfunction

   function automatic logic [47:0] near_position();
      return {near_coord(), near_coord(), near_coord()};
   endfunction

   task automatic run_random(int count);
      repeat (count) send_fragment(random_fragment());
   endtask

   initial begin
      fragment_type f;
      sb.set_defaults();
      idle_pct = 36;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed corners under reset settings
      send_fragment('{8'd255, 8'd255, 8'd255, 16'sd0, 16'sd0, 16'sd16384, 0, 0, 0});
      send_fragment('{8'd0, 8'd0, 8'd0, 16'sd0, 16'sd0, 16'sd16384, 0, 0, 0});
      // zero normal
      send_fragment('{8'd200, 8'd100, 8'd50, 16'sd0, 16'sd0, 16'sd0, 0, 0, 0});
      // point at 20.0 on every axis, normal in the x-y plane
      send_fragment('{8'd255, 8'd128, 8'd1, 16'sd16384, 16'sd16384, 16'sd0,
                      16'sd5120, 16'sd5120, 16'sd5120});
      // eye at the point
      send_fragment('{8'd90, 8'd180, 8'd255, 16'sd0, 16'sd0, 16'sd16384, 0, 0, 16'sd2560});
      // light opposite the eye
      send_fragment('{8'd255, 8'd255, 8'd255, 16'sd0, 16'sd16384, 16'sd0,
                      -16'sd2560, 16'sd2560, 16'sd1280});
      send_fragment('{8'd255, 8'd0, 8'd255, -16'sd32768, -16'sd32768, -16'sd32768,
                      -16'sd32768, -16'sd32768, -16'sd32768});
      send_fragment('{8'd0, 8'd255, 8'd0, 16'sd32767, 16'sd32767, 16'sd32767,
                      16'sd32767, 16'sd32767, 16'sd32767});
      send_fragment('{8'd170, 8'd85, 8'd15, 16'sd32767, -16'sd32768, 16'sd1,
                      -16'sd32768, 16'sd32767, 16'sd0});
      send_fragment('{8'd255, 8'd255, 8'd255, -16'sd1, 16'sd0, 16'sd0, 16'sd1, 0, -16'sd1});
      run_random(140);
      drain();

      // extreme settings, unmapped writes must be ignored
      csr_write(CSR_SPARE_LO, '1);
      csr_write(CSR_SPARE_HI, '0);
      csr_write(bps_pkg::CSR_LIGHT_A, 48'h7fff_7fff_7fff);
      csr_write(bps_pkg::CSR_LIGHT_B, 48'h8000_8000_8000);
      csr_write(bps_pkg::CSR_EYE, 48'hffff_ffff_ffff);
      csr_write(bps_pkg::CSR_INTENSITY, 48'hffff_ffff_ffff);
      csr_write(bps_pkg::CSR_AMBIENT, 48'h0000_0000_ffff);
      csr_write(bps_pkg::CSR_SPECULAR, 48'h1234_5678_ffff);
      f = '{8'd255, 8'd255, 8'd255, 16'sd0, 16'sd0, 16'sd16384, 16'sd32767, 16'sd32767,
            16'sd32767};
      send_fragment(f);
      run_random(140);
      drain();

      idle_pct = 57;
      csr_write(bps_pkg::CSR_LIGHT_A, '0);
      csr_write(bps_pkg::CSR_LIGHT_B, '0);
      csr_write(bps_pkg::CSR_EYE, '0);
      csr_write(bps_pkg::CSR_INTENSITY, '0);
      csr_write(bps_pkg::CSR_AMBIENT, '0);
      csr_write(bps_pkg::CSR_SPECULAR, '0);
      send_fragment('{8'd255, 8'd255, 8'd255, 0, 0, 16'sd16384, 0, 0, 0});
      run_random(100);
      drain();

      csr_write(bps_pkg::CSR_LIGHT_A, near_position());
      csr_write(bps_pkg::CSR_LIGHT_B, near_position());
      csr_write(bps_pkg::CSR_EYE, near_position());
      csr_write(bps_pkg::CSR_INTENSITY, 48'($urandom_range(65535)));
      csr_write(bps_pkg::CSR_AMBIENT, 48'($urandom_range(65535)));
      csr_write(bps_pkg::CSR_SPECULAR, 48'($urandom_range(65535)));
      run_random(130);
      drain();

      idle_pct = 0;
      csr_write(bps_pkg::CSR_LIGHT_A, bps_pkg::LIGHT_A_RESET);
      csr_write(bps_pkg::CSR_LIGHT_B, bps_pkg::LIGHT_B_RESET);
      csr_write(bps_pkg::CSR_EYE, bps_pkg::EYE_RESET);
      csr_write(bps_pkg::CSR_INTENSITY, 48'(bps_pkg::INTENSITY_RESET));
      csr_write(bps_pkg::CSR_AMBIENT, 48'(bps_pkg::AMBIENT_RESET));
      csr_write(bps_pkg::CSR_SPECULAR, 48'(bps_pkg::SPECULAR_RESET));
      run_random(230);

      drain();
      repeat (160) @(posedge clock);
      if (sb.errors == 0 && sb.expected_q.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         if (sb.expected_q.size() != 0)
            $error("%0d expected results never arrived", sb.expected_q.size());
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $error("timeout");
      $display("Test completed with failures");
      $finish;
   end

endmodule
